@@ rtl/core/swhc_pkg.sv @@
// shared types and constants of the sliding window hit counter
`timescale 1ns / 1ps

package swhc_pkg;

  // fixed field widths of one item
  localparam int unsigned TIME_W   = 31;
  localparam int unsigned SUM_W    = 41;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;

  // staging queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    OP_HIT   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_MOD,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_HIT_RD,
    BK_HIT_WR,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } back_state_e;

endpackage

@@ rtl/core/swhc_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module swhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/swhc_front.sv @@
// front end: accepts items and works out the bucket index of hits
`timescale 1ns / 1ps

module swhc_front #(
  parameter int unsigned WINDOW = 300,
  parameter int unsigned AW     = $clog2(WINDOW),
  parameter int unsigned ENT_W  = 1 + swhc_pkg::TIME_W + AW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swhc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  logic                                clearing_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output logic [ENT_W-1:0]                    q_data_o
);

  localparam int unsigned TW = swhc_pkg::TIME_W;
  // reciprocal of the window scaled by 2^(TW+AW), exact for every TW-bit time
  localparam longint unsigned RECIP = ((64'd1 << (TW + AW)) / WINDOW) + 64'd1;

  swhc_pkg::front_state_e state_q, state_d;
  logic                        op_q, op_d;
  logic [TW-1:0]               time_q, time_d;
  logic [AW-1:0]               rem_q, rem_d;
  logic [2*TW:0]               prod_q, prod_d;
  logic [TW-AW:0]              quo;
  logic [TW-1:0]               rem_full;
  logic                        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swhc_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    time_q  <= time_d;
    rem_q   <= rem_d;
    prod_q  <= prod_d;
  end

  // time mod window: quotient by reciprocal multiply, then one multiply-subtract
  assign prod_d   = (2*TW+1)'(time_q) * (2*TW+1)'(RECIP);
  assign quo      = prod_q[2*TW:TW+AW];
  assign rem_full = time_q - TW'(quo) * TW'(WINDOW);

  assign s_axis_tready = (state_q == swhc_pkg::FR_IDLE) && !clearing_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    time_d        = time_q;
    rem_d         = rem_q;
    q_push_o      = 1'b0;
    case (state_q)
      swhc_pkg::FR_IDLE: begin
        if (accept) begin
          op_d    = s_axis_tuser;
          time_d  = s_axis_tdata[TW-1:0];
          rem_d   = '0;
          // queries need no bucket index
          if (s_axis_tuser == swhc_pkg::OP_QUERY) begin
            state_d = swhc_pkg::FR_PUSH;
          end else begin
            state_d = swhc_pkg::FR_MUL;
          end
        end
      end
      swhc_pkg::FR_MUL: begin
        state_d = swhc_pkg::FR_MOD;
      end
      swhc_pkg::FR_MOD: begin
        rem_d   = rem_full[AW-1:0];
        state_d = swhc_pkg::FR_PUSH;
      end
      swhc_pkg::FR_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = swhc_pkg::FR_IDLE;
        end
      end
      default: begin
        state_d = swhc_pkg::FR_IDLE;
      end
    endcase
  end

  // entry layout from the lowest bit: op, time, slot
  assign q_data_o = {rem_q, time_q, op_q};

endmodule

@@ rtl/core/swhc_queue.sv @@
// short fifo between front end and back end
`timescale 1ns / 1ps

module swhc_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned CNT_W = $clog2(swhc_pkg::QUEUE_DEPTH + 1);

  logic [DATA_W-1:0]           entry_q [swhc_pkg::QUEUE_DEPTH];
  logic [swhc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]            count_q;

  assign full_o     = count_q == CNT_W'(swhc_pkg::QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/swhc_back.sv @@
// back end: bucket updates, window scan and result register
`timescale 1ns / 1ps

module swhc_back #(
  parameter int unsigned WINDOW      = 300,
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned AW          = $clog2(WINDOW),
  parameter int unsigned ENT_W       = 1 + swhc_pkg::TIME_W + AW
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  logic [ENT_W-1:0]                 q_data_i,
  output logic                             q_pop_o,
  output logic                             clearing_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [swhc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned TW    = swhc_pkg::TIME_W;
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned OW    = swhc_pkg::SUM_W;
  localparam int unsigned WORD_W = TW + CW;
  localparam int unsigned SW    = ((CW > OW) ? CW : OW) + 1;

  swhc_pkg::back_state_e state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [TW-1:0]     time_q, time_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic              v1_q, v2_q;
  logic [CW-1:0]     mcnt_q;
  logic [OW-1:0]     acc_q;
  logic              acc_clr;
  logic              out_valid_q;
  logic [OW-1:0]     out_data_q;
  logic              out_load;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;
  logic [TW-1:0]     rd_time;
  logic [CW-1:0]     rd_cnt;
  logic signed [TW:0] age;
  logic              in_win;
  logic [SW-1:0]     sum;

  // word layout: time in the low bits, count above
  swhc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_time = rdata[TW-1:0];
  assign rd_cnt  = rdata[WORD_W-1:TW];

  // signed age; a bucket stamped later than the query counts as inside
  assign age    = $signed({1'b0, time_q}) - $signed({1'b0, rd_time});
  assign in_win = age < $signed((TW+1)'(WINDOW));
  assign sum    = SW'(acc_q) + SW'(mcnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swhc_pkg::BK_CLEAR;
      addr_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      v1_q    <= state_q == swhc_pkg::BK_SCAN;
      v2_q    <= v1_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    slot_q <= slot_d;
    mcnt_q <= in_win ? rd_cnt : '0;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      // saturating add, the running sum only grows
      if (sum[SW-1:OW] != '0) begin
        acc_q <= '1;
      end else begin
        acc_q <= sum[OW-1:0];
      end
    end
    if (out_load) begin
      out_data_q <= acc_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    time_d     = time_q;
    slot_d     = slot_q;
    acc_clr    = 1'b0;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    we         = 1'b0;
    waddr      = slot_q;
    wdata      = '0;
    raddr      = slot_q;
    clearing_o = 1'b0;
    case (state_q)
      swhc_pkg::BK_CLEAR: begin
        clearing_o = 1'b1;
        we         = 1'b1;
        waddr      = addr_q;
        addr_d     = addr_q + 1'b1;
        if (addr_q == AW'(WINDOW - 1)) begin
          addr_d  = '0;
          state_d = swhc_pkg::BK_IDLE;
        end
      end
      swhc_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          time_d  = q_data_i[TW:1];
          slot_d  = q_data_i[ENT_W-1:TW+1];
          addr_d  = '0;
          acc_clr = 1'b1;
          if (q_data_i[0] == swhc_pkg::OP_QUERY) begin
            state_d = swhc_pkg::BK_SCAN;
          end else begin
            state_d = swhc_pkg::BK_HIT_RD;
          end
        end
      end
      swhc_pkg::BK_HIT_RD: begin
        state_d = swhc_pkg::BK_HIT_WR;
      end
      swhc_pkg::BK_HIT_WR: begin
        we = 1'b1;
        if (rd_time != time_q) begin
          wdata = {CW'(1), time_q};
        end else if (rd_cnt != '1) begin
          wdata = {rd_cnt + 1'b1, time_q};
        end else begin
          wdata = {rd_cnt, time_q};
        end
        state_d = swhc_pkg::BK_IDLE;
      end
      swhc_pkg::BK_SCAN: begin
        raddr  = addr_q;
        addr_d = addr_q + 1'b1;
        if (addr_q == AW'(WINDOW - 1)) begin
          addr_d  = '0;
          state_d = swhc_pkg::BK_DRAIN;
        end
      end
      swhc_pkg::BK_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = swhc_pkg::BK_DONE;
        end
      end
      swhc_pkg::BK_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = swhc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = swhc_pkg::BK_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = swhc_pkg::OUT_TDATA_W'(out_data_q);

endmodule

@@ rtl/core/sliding_window_hit_counter_unit.sv @@
// top level of the sliding window hit counter
// a hit reaches its bucket after the index multiply, the queue and the bucket update
// a query result follows a scan over all WINDOW buckets
// the front takes a new item only once the last is pushed; the back end handles one item at a time
// reset: asynchronous active low; afterwards a clearing pass zeroes every bucket,
// and no item is accepted until it ends
`timescale 1ns / 1ps

module sliding_window_hit_counter_unit #(
  parameter int unsigned WINDOW      = 300,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [swhc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [30:0] time_sec, [31] zero
  input  logic                             s_axis_tuser,  // [0] op
  // result items, one per query
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [swhc_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [40:0] window_count, [47:41] zero
);

  // bucket index width and queue entry width
  localparam int unsigned AW    = $clog2(WINDOW);
  localparam int unsigned ENT_W = 1 + swhc_pkg::TIME_W + AW;

  logic             clearing;
  logic             q_push;
  logic [ENT_W-1:0] q_push_data;
  logic             q_pop;
  logic [ENT_W-1:0] q_pop_data;
  logic             q_full;
  logic             q_empty;

  // front end: takes items, runs time_sec mod WINDOW for hits
  swhc_front #(
    .WINDOW (WINDOW),
    .AW     (AW),
    .ENT_W  (ENT_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing_i    (clearing),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_push_data)
  );

  // decouples index computation from bucket access
  swhc_queue #(
    .DATA_W (ENT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // back end: bucket ram, hit update, window scan, result register
  swhc_back #(
    .WINDOW      (WINDOW),
    .COUNT_WIDTH (COUNT_WIDTH),
    .AW          (AW),
    .ENT_W       (ENT_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_pop_data),
    .q_pop_o       (q_pop),
    .clearing_o    (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // no item taken while the clearing pass runs
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  // front never pushes into a full queue
  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue overflow");

  // back never pops an empty queue
  a_no_queue_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue underflow");

  // no result can appear before the buckets are cleared
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !m_axis_tvalid)
    else $error("result during clearing pass");
`endif

endmodule

@@ tb/sv/sliding_window_hit_counter_unit_tb.sv @@
// self-checking testbench of the sliding window hit counter
`timescale 1ns / 1ps

module sliding_window_hit_counter_unit_tb;

  localparam int unsigned WIN       = 300;
  localparam int unsigned CNT_W     = 32;
  localparam longint unsigned TIME_MAX  = (64'd1 << swhc_pkg::TIME_W) - 1;
  localparam longint unsigned COUNT_TOP = (64'd1 << CNT_W) - 1;
  localparam longint unsigned SUM_TOP   = (64'd1 << swhc_pkg::SUM_W) - 1;
  localparam int unsigned N_ITEMS   = 1050;
  localparam int unsigned LONG_HOLD = 4000;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    swhc_pkg::op_e op;
    bit [30:0]     tsec;
    bit            drain;  // marker: hold the sender until all counts are back
  } hit_item_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [swhc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [30:0] time_sec, [31] zero
  logic                             s_axis_tuser = 1'b0; // [0] op
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [swhc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // [40:0] window_count, [47:41] zero

  sliding_window_hit_counter_unit #(
    .WINDOW      (WIN),
    .COUNT_WIDTH (CNT_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow copy of the bucket stores
  bit [swhc_pkg::TIME_W-1:0] bucket_stamp [WIN];
  bit [CNT_W-1:0]            bucket_hits  [WIN];

  hit_item_t                pending_items [$];
  bit [swhc_pkg::SUM_W-1:0] window_count_q [$];  // counts owed by queries in flight

  hit_item_t   cur_item;
  bit          nxt_valid;
  bit          nxt_ready;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned roll;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned stalled_cycles;
  int unsigned errors;
  bit          long_hold_done;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // sum of all buckets whose stamp lies less than WIN seconds before t,
  // stamps later than t included
  function automatic bit [swhc_pkg::SUM_W-1:0] sum_in_window(bit [swhc_pkg::TIME_W-1:0] t);
    longint age;
    longint unsigned total;
    total = 0;
    for (int i = 0; i < WIN; i++) begin
      age = longint'({33'b0, t}) - longint'({33'b0, bucket_stamp[i]});
      if (age < longint'(WIN))
        total += bucket_hits[i];
    end
    if (total > SUM_TOP)
      total = SUM_TOP;
    return total[swhc_pkg::SUM_W-1:0];
  endfunction

  // update the shadow buckets for one accepted item, queue the count a query owes
  function automatic void apply_to_buckets(hit_item_t it);
    int unsigned slot;
    slot = it.tsec % WIN;
    if (it.op == swhc_pkg::OP_QUERY) begin
      window_count_q.push_back(sum_in_window(it.tsec));
    end else if (bucket_stamp[slot] != it.tsec) begin
      bucket_stamp[slot] = it.tsec;
      bucket_hits[slot]  = 1;
    end else if (bucket_hits[slot] < COUNT_TOP) begin
      bucket_hits[slot] = bucket_hits[slot] + 1;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic push_op(swhc_pkg::op_e op, longint unsigned t);
    hit_item_t it;
    it.op    = op;
    it.tsec  = t[swhc_pkg::TIME_W-1:0];
    it.drain = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic push_drain();
    hit_item_t it;
    it.op    = swhc_pkg::OP_HIT;
    it.tsec  = '0;
    it.drain = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic push_directed();
    // time zero hits land on buckets still holding their reset stamp
    push_op(swhc_pkg::OP_HIT, 0);
    push_op(swhc_pkg::OP_HIT, 0);
    push_op(swhc_pkg::OP_QUERY, 0);
    // last second still inside the window, then just outside
    push_op(swhc_pkg::OP_QUERY, WIN - 1);
    push_op(swhc_pkg::OP_QUERY, WIN);
    // new stamp restarts bucket zero
    push_op(swhc_pkg::OP_HIT, WIN);
    push_op(swhc_pkg::OP_QUERY, WIN);
    // largest timestamp
    push_op(swhc_pkg::OP_HIT, TIME_MAX);
    push_op(swhc_pkg::OP_HIT, TIME_MAX);
    push_op(swhc_pkg::OP_QUERY, TIME_MAX);
    // timestamps going backwards: later stamps count as inside
    push_op(swhc_pkg::OP_QUERY, 5);
    push_op(swhc_pkg::OP_HIT, 5);
    push_op(swhc_pkg::OP_HIT, 5);
    push_op(swhc_pkg::OP_QUERY, 5);
    push_op(swhc_pkg::OP_HIT, 1);
    push_op(swhc_pkg::OP_QUERY, 1);
    push_op(swhc_pkg::OP_QUERY, TIME_MAX - WIN);
    push_op(swhc_pkg::OP_QUERY, TIME_MAX - WIN + 1);
    push_op(swhc_pkg::OP_HIT, 32'h2AAA_AAAA);
    push_op(swhc_pkg::OP_HIT, 32'h5555_5555);
    push_op(swhc_pkg::OP_QUERY, 32'h5555_5555);
  endtask

  task automatic push_random();
    longint unsigned cur_t;
    int unsigned seg_kind;
    int unsigned seg_len;
    int unsigned r;
    bit drained;
    swhc_pkg::op_e op;
    cur_t   = 0;
    drained = 1'b0;
    while (pending_items.size() < N_ITEMS) begin
      // once, halfway through, wait for every owed count
      if (!drained && pending_items.size() > N_ITEMS / 2) begin
        push_drain();
        drained = 1'b1;
      end
      seg_kind = $urandom_range(9, 0);
      seg_len  = $urandom_range(60, 20);
      // most segments are ascending runs; some restart at a far base
      if (seg_kind < 7 && $urandom_range(3, 0) == 0) begin
        if ($urandom_range(7, 0) == 0)
          cur_t = TIME_MAX - $urandom_range(500, 0);
        else
          cur_t = $urandom_range(TIME_MAX - 5000, 0);
      end
      for (int n = 0; n < seg_len; n++) begin
        op = ($urandom_range(99, 0) < 30) ? swhc_pkg::OP_QUERY : swhc_pkg::OP_HIT;
        if (seg_kind < 7) begin
          r = $urandom_range(99, 0);
          if (r < 60)
            cur_t += 0;
          else if (r < 90)
            cur_t += $urandom_range(3, 1);
          else if (r < 97)
            cur_t += $urandom_range(400, 4);
          else
            cur_t += $urandom_range(2000, 300);
          if (cur_t > TIME_MAX)
            cur_t = TIME_MAX;
          push_op(op, cur_t);
        end else if (seg_kind < 9) begin
          // noise over the whole time range
          push_op(op, longint'($urandom()) & TIME_MAX);
        end else begin
          // broken order: slowly stepping back
          r = $urandom_range(5, 0);
          cur_t = (cur_t > r) ? cur_t - r : 0;
          push_op(op, cur_t);
        end
      end
    end
  endtask

  // sender: one pending item at a time, random gaps between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      gap_left   = 0;
      items_sent = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_to_buckets(cur_item);
        items_sent++;
        nxt_valid = 1'b0;
        gap_left  = (items_sent % 200 < 40) ? 0 : pick_gap();
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          if (pending_items[0].drain) begin
            if (window_count_q.size() == 0)
              void'(pending_items.pop_front());
          end else begin
            cur_item = pending_items.pop_front();
            nxt_valid = 1'b1;
            s_axis_tdata <= {1'b0, cur_item.tsec};
            s_axis_tuser <= cur_item.op;
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // receiver: checks each count, stalls at random, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left      = 0;
      results_seen   = 0;
      long_hold_done = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (window_count_q.size() == 0) begin
          $display("%0t: unexpected count, expected none, actual %0d", $time,
                   m_axis_tdata);
          errors++;
        end else if (m_axis_tdata !== {{(swhc_pkg::OUT_TDATA_W - swhc_pkg::SUM_W){1'b0}},
                                       window_count_q[0]}) begin
          $display("%0t: window_count mismatch, expected %0d, actual %0d", $time,
                   window_count_q[0], m_axis_tdata);
          errors++;
          void'(window_count_q.pop_front());
        end else begin
          void'(window_count_q.pop_front());
        end
        results_seen++;
      end
      if (results_seen == 60 && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (results_seen % 50 < 10) begin
        nxt_ready = 1'b1;
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 70) begin
          nxt_ready = 1'b1;
        end else if (roll < 95) begin
          hold_left = $urandom_range(3, 1);
          nxt_ready = 1'b0;
        end else begin
          hold_left = $urandom_range(60, 10);
          nxt_ready = 1'b0;
        end
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("[sliding_window_hit_counter_unit] ERROR");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    stalled_cycles = 0;
    push_directed();
    push_random();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do
      @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || window_count_q.size() != 0);
    // catch any stray count the block might still send
    repeat (WIN + 40) @(posedge clk_i);
    if (errors == 0)
      $display("[sliding_window_hit_counter_unit] OK");
    else
      $display("[sliding_window_hit_counter_unit] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/swhc_pkg.sv
rtl/core/swhc_ram.sv
rtl/core/swhc_front.sv
rtl/core/swhc_queue.sv
rtl/core/swhc_back.sv
rtl/core/sliding_window_hit_counter_unit.sv
tb/sv/sliding_window_hit_counter_unit_tb.sv
